// ===== hw/rtl/periodic_task_timer_table_defines.svh =====
// -----------------------------------------------------------------------------
// periodic_task_timer_table_defines.svh
// Assertion macros used by the timer table checker.
// -----------------------------------------------------------------------------
`ifndef PERIODIC_TASK_TIMER_TABLE_DEFINES_SVH
`define PERIODIC_TASK_TIMER_TABLE_DEFINES_SVH

// Checked only while out of reset.
`define PTT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked on every edge, reset included.
`define PTT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== hw/rtl/ptt_pkg.sv =====
// -----------------------------------------------------------------------------
// ptt_pkg
// Constants, codes and shared types of the periodic task timer table.
// -----------------------------------------------------------------------------
package ptt_pkg;

    localparam int TASK_SLOTS  = 8;
    localparam int PERIOD_BITS = 16;
    localparam int IDX_BITS    = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam int FIRED_W     = 8;
    localparam int ID_W        = 4;
    localparam int PERIOD_IN_W = 16;

    // item kinds
    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_START = 2'd1;
    localparam logic [1:0] KIND_STOP  = 2'd2;

    typedef struct packed {
        logic [1:0]             kind;
        logic [ID_W-1:0]        task_id;
        logic [PERIOD_IN_W-1:0] period;
        logic                   one_shot;
    } ptt_item_t;

    typedef struct packed {
        logic               status;
        logic [FIRED_W-1:0] fired_mask;
        logic               timer_enabled;
    } ptt_result_t;

    // controller -> datapath
    typedef struct packed {
        logic                capture;
        logic                exec;
        logic                walk;
        logic [IDX_BITS-1:0] walk_idx;
        logic                out_load;
    } ptt_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic base_due;
    } ptt_sts_t;

endpackage

// ===== hw/rtl/ptt_datapath.sv =====
// -----------------------------------------------------------------------------
// ptt_datapath
// Slot tables, prescaler, single countdown unit and result register.
// -----------------------------------------------------------------------------
module ptt_datapath (
    input  logic               aclk,
    input  logic               aresetn,
    input  ptt_pkg::ptt_cmd_t  cmd,
    output ptt_pkg::ptt_sts_t  sts,
    input  ptt_pkg::ptt_item_t item,
    input  logic [7:0]         ticks_per_base,
    output ptt_pkg::ptt_result_t result
);
    import ptt_pkg::*;

    // captured item
    logic [1:0]             kind_reg;
    logic [ID_W-1:0]        id_reg;
    logic [PERIOD_BITS-1:0] period_reg;
    logic                   once_reg;

    // slot tables
    logic [PERIOD_BITS-1:0] slot_period_reg [TASK_SLOTS];
    logic [PERIOD_BITS-1:0] slot_rem_reg    [TASK_SLOTS];
    logic                   slot_once_reg   [TASK_SLOTS];

    logic [TASK_SLOTS-1:0] active_reg, active_next;
    logic [7:0]            pc_reg, pc_next;
    logic                  en_reg, en_next;
    logic                  tick_reg, tick_next;
    logic                  status_reg, status_next;
    logic [FIRED_W-1:0]    fired_reg, fired_next;

    logic                  out_status_reg;
    logic [FIRED_W-1:0]    out_fired_reg;
    logic                  out_en_reg;

    logic                   id_ok;
    logic [IDX_BITS-1:0]    id_sel;
    logic [7:0]             pc_inc;
    logic [PERIOD_BITS-1:0] rem_dec;
    logic                   start_wr;
    logic                   rem_wr;
    logic [PERIOD_BITS-1:0] rem_wdata;
    logic                   en_final;

    assign id_ok   = ({1'b0, id_reg} < (ID_W + 1)'(TASK_SLOTS));
    assign id_sel  = id_reg[IDX_BITS-1:0];
    assign pc_inc  = pc_reg + 8'd1;
    assign rem_dec = slot_rem_reg[cmd.walk_idx] - PERIOD_BITS'(1);

    assign sts.base_due = (kind_reg == KIND_TICK) && en_reg && (pc_inc == ticks_per_base);

    // a base tick ends with ticking off once every slot has gone idle
    assign en_final = tick_reg ? (|active_reg) : en_reg;

    always_comb begin
        integer j;
        active_next = active_reg;
        pc_next     = pc_reg;
        en_next     = en_reg;
        tick_next   = tick_reg;
        status_next = status_reg;
        fired_next  = fired_reg;
        start_wr    = 1'b0;
        rem_wr      = 1'b0;
        rem_wdata   = rem_dec;

        if (cmd.exec) begin
            status_next = 1'b0;
            fired_next  = '0;
            tick_next   = 1'b0;
            case (kind_reg)
                KIND_TICK: begin
                    if (en_reg) begin
                        if (pc_inc == ticks_per_base) begin
                            pc_next   = 8'd0;
                            tick_next = 1'b1;
                        end else begin
                            pc_next = pc_inc;
                        end
                    end
                end
                KIND_START: begin
                    if (!id_ok || (period_reg == '0)) begin
                        status_next = 1'b1;
                    end else begin
                        start_wr            = 1'b1;
                        active_next[id_sel] = 1'b1;
                        en_next             = 1'b1;
                    end
                end
                KIND_STOP: begin
                    if (!id_ok || !active_reg[id_sel]) begin
                        status_next = 1'b1;
                    end else begin
                        active_next[id_sel] = 1'b0;
                        en_next             = |active_next;
                    end
                end
                default: begin
                    status_next = 1'b1;
                end
            endcase
        end

        // one slot per cycle through the shared decrement
        if (cmd.walk && active_reg[cmd.walk_idx]) begin
            rem_wr = 1'b1;
            if (rem_dec == '0) begin
                rem_wdata = slot_period_reg[cmd.walk_idx];
                for (j = 0; j < FIRED_W; j++) begin
                    if (32'(cmd.walk_idx) == j) begin
                        fired_next[j] = 1'b1;
                    end
                end
                if (slot_once_reg[cmd.walk_idx]) begin
                    active_next[cmd.walk_idx] = 1'b0;
                end
            end
        end

        if (cmd.out_load) begin
            en_next = en_final;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= '0;
            pc_reg     <= 8'd0;
            en_reg     <= 1'b0;
            tick_reg   <= 1'b0;
            status_reg <= 1'b0;
            fired_reg  <= '0;
        end else begin
            active_reg <= active_next;
            pc_reg     <= pc_next;
            en_reg     <= en_next;
            tick_reg   <= tick_next;
            status_reg <= status_next;
            fired_reg  <= fired_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            kind_reg   <= item.kind;
            id_reg     <= item.task_id;
            period_reg <= PERIOD_BITS'(item.period);
            once_reg   <= item.one_shot;
        end
        if (start_wr) begin
            slot_period_reg[id_sel] <= period_reg;
            slot_once_reg[id_sel]   <= once_reg;
        end
        if (start_wr) begin
            slot_rem_reg[id_sel] <= period_reg;
        end else if (rem_wr) begin
            slot_rem_reg[cmd.walk_idx] <= rem_wdata;
        end
        if (cmd.out_load) begin
            out_status_reg <= status_reg;
            out_fired_reg  <= fired_reg;
            out_en_reg     <= en_final;
        end
    end

    assign result.status        = out_status_reg;
    assign result.fired_mask    = out_fired_reg;
    assign result.timer_enabled = out_en_reg;

endmodule

// ===== hw/rtl/ptt_ctrl.sv =====
// -----------------------------------------------------------------------------
// ptt_ctrl
// Sequencer: capture, execute, slot walk and result handoff.
// -----------------------------------------------------------------------------
module ptt_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output ptt_pkg::ptt_cmd_t cmd,
    input  ptt_pkg::ptt_sts_t sts
);
    import ptt_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_WALK = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    localparam logic [IDX_BITS-1:0] IDX_LAST = IDX_BITS'(TASK_SLOTS - 1);

    logic [1:0]          state_reg, state_next;
    logic [IDX_BITS-1:0] idx_reg, idx_next;
    logic                out_valid_reg, out_valid_next;

    always_comb begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        s_tready     = 1'b0;
        cmd          = '0;
        cmd.walk_idx = idx_reg;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC: begin
                cmd.exec = 1'b1;
                if (sts.base_due) begin
                    idx_next   = '0;
                    state_next = S_WALK;
                end else begin
                    state_next = S_OUT;
                end
            end
            S_WALK: begin
                cmd.walk = 1'b1;
                if (idx_reg == IDX_LAST) begin
                    state_next = S_OUT;
                end else begin
                    idx_next = idx_reg + IDX_BITS'(1);
                end
            end
            S_OUT: begin
                if (!out_valid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid_next = cmd.out_load ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
    assign m_tvalid       = out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== hw/rtl/periodic_task_timer_table.sv =====
// -----------------------------------------------------------------------------
// periodic_task_timer_table: start/stop/tick timer table with prescaler
// Sequence: capture, execute, a walk of every slot on a base tick, then the result register.
// Transactions are taken one at a time; the next is taken once the previous result is loaded.
// Reset (aresetn low, synchronous): slots idle, ticking off, prescaler 0, ticks_per_base 1.
// -----------------------------------------------------------------------------
module periodic_task_timer_table (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // task_id[3:0], period[19:4], one_shot[20], zero[23:21]
    input  logic [1:0]  s_tuser,   // kind[1:0]
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // status[0], fired_mask[8:1], timer_enabled[9], zero[15:10]
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import ptt_pkg::*;

    localparam logic REG_TICKS_PER_BASE = 1'b0;

    ptt_cmd_t    cmd;
    ptt_sts_t    sts;
    ptt_item_t   item;
    ptt_result_t result;

    logic [7:0] tpb_reg, tpb_next;
    logic       cfg_wr;

    // Register write: completes in the access phase, pready tied high.
    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && (paddr[2] == REG_TICKS_PER_BASE);
    assign tpb_next = cfg_wr ? pwdata[7:0] : tpb_reg;
    assign prdata   = (paddr[2] == REG_TICKS_PER_BASE) ? {24'd0, tpb_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tpb_reg <= 8'd1;
        end else begin
            tpb_reg <= tpb_next;
        end
    end

    // Unpack the input transaction.
    assign item.kind     = s_tuser;
    assign item.task_id  = s_tdata[3:0];
    assign item.period   = s_tdata[19:4];
    assign item.one_shot = s_tdata[20];

    // Sequencer owns both handshakes; the result register decouples the output side
    // so a new transaction is taken while the previous result waits.
    ptt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    // Slot tables, prescaler and the countdown walked one slot per cycle.
    ptt_datapath u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .sts            (sts),
        .item           (item),
        .ticks_per_base (tpb_reg),
        .result         (result)
    );

    assign m_tdata = {6'd0, result.timer_enabled, result.fired_mask, result.status};

endmodule

// ===== hw/rtl/ptt_checker.sv =====
// -----------------------------------------------------------------------------
// ptt_checker
// Port-level checks of the timer table, bound to the top level.
// -----------------------------------------------------------------------------
`include "periodic_task_timer_table_defines.svh"

module ptt_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    `PTT_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result dropped or changed while stalled")
    `PTT_ASSERT(a_one_at_a_time, s_tvalid && s_tready |=> !s_tready, "second transaction taken while one is in work")
    `PTT_ASSERT(a_fire_ok, m_tvalid && (m_tdata[8:1] != 8'd0) |-> !m_tdata[0], "slots fired on an error result")
    `PTT_ASSERT_ALWAYS(a_reset_quiet, !aresetn |=> !m_tvalid, "result valid right after reset")

endmodule

bind periodic_task_timer_table ptt_checker u_ptt_checker (.*);

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// tb: periodic task timer table testbench
// Streams start, stop, raw tick and malformed transactions into the timer
// table and predicts every result with an in-bench copy of the slot table and
// prescaler. Results are compared field by field in arrival order. The
// prescale setting is changed between phases while the block is idle; the
// sender runs in bursts and the receiver stalls in several patterns,
// including one long hold that backs the block up.
// -----------------------------------------------------------------------------
module tb;
    import ptt_pkg::*;

    // kind code with no meaning in the block; must be rejected
    localparam logic [1:0] KIND_BAD = 2'd3;
    // register map
    localparam logic [2:0] ADDR_TICKS_PER_BASE = 3'd0;
    // cycles allowed after the last result before touching the register
    localparam int IDLE_SETTLE = TASK_SLOTS + 8;
    // length of the long receiver hold-off
    localparam int LONG_HOLD = 300;
    // max mismatch lines printed; all are counted
    localparam int PRINT_CAP = 40;

    typedef enum int {RX_ALWAYS, RX_COIN, RX_PATTERN, RX_SPARSE} rx_mode_t;

    // ---------------------------------------------------------------------
    // clock, reset, DUT ports (all inputs known from time zero)
    // ---------------------------------------------------------------------
    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;   // task_id[3:0], period[19:4], one_shot[20], zero[23:21]
    logic [1:0]  s_tuser  = '0;   // kind[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;         // status[0], fired_mask[8:1], timer_enabled[9], zero[15:10]
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    periodic_task_timer_table u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // ---------------------------------------------------------------------
    // timer table predictor state
    // ---------------------------------------------------------------------
    logic [PERIOD_BITS-1:0] tbl_period [TASK_SLOTS];
    logic [PERIOD_BITS-1:0] tbl_left   [TASK_SLOTS];
    logic                   tbl_once   [TASK_SLOTS];
    logic                   tbl_active [TASK_SLOTS] = '{default: 1'b0};
    logic [7:0]             pre_cnt   = 8'd0;
    logic [7:0]             cfg_tpb   = 8'd1;   // ticks_per_base after reset
    logic                   tick_en   = 1'b0;

    ptt_item_t   pending_items [$];     // transactions waiting for the driver
    ptt_result_t expected_results [$];  // predicted results, oldest first

    int       err_count = 0;
    int       tx_gap_max = 0;           // 0: sender never pauses
    rx_mode_t rx_mode = RX_ALWAYS;
    int       hold_asks = 0;            // bumped to request one long hold

    function automatic logic any_slot_active();
        for (int k = 0; k < TASK_SLOTS; k++)
            if (tbl_active[k])
                return 1'b1;
        return 1'b0;
    endfunction

    // One transaction into the table; returns the result it should produce.
    function automatic ptt_result_t advance_timers(ptt_item_t it);
        ptt_result_t r;
        logic [PERIOD_BITS-1:0] per;
        logic [IDX_BITS-1:0]    sid;
        r   = '0;
        per = it.period[PERIOD_BITS-1:0];
        sid = it.task_id[IDX_BITS-1:0];
        case (it.kind)
            KIND_TICK: begin
                // raw ticks only count while some slot is running
                if (tick_en) begin
                    pre_cnt = pre_cnt + 8'd1;
                    if (pre_cnt == cfg_tpb) begin
                        pre_cnt = 8'd0;
                        for (int k = 0; k < TASK_SLOTS; k++) begin
                            if (tbl_active[k]) begin
                                tbl_left[k] = tbl_left[k] - 1'b1;
                                if (tbl_left[k] == '0) begin
                                    if (k < FIRED_W)
                                        r.fired_mask[k] = 1'b1;
                                    tbl_left[k] = tbl_period[k];
                                    if (tbl_once[k])
                                        tbl_active[k] = 1'b0;
                                end
                            end
                        end
                        if (!any_slot_active())
                            tick_en = 1'b0;
                    end
                end
            end
            KIND_START: begin
                if (it.task_id >= TASK_SLOTS || per == '0) begin
                    r.status = 1'b1;
                end else begin
                    tbl_period[sid] = per;
                    tbl_left[sid]   = per;
                    tbl_once[sid]   = it.one_shot;
                    tbl_active[sid] = 1'b1;
                    tick_en = 1'b1;
                end
            end
            KIND_STOP: begin
                if (it.task_id >= TASK_SLOTS || !tbl_active[sid]) begin
                    r.status = 1'b1;
                end else begin
                    tbl_active[sid] = 1'b0;
                    if (!any_slot_active())
                        tick_en = 1'b0;
                end
            end
            default: r.status = 1'b1;
        endcase
        r.timer_enabled = tick_en;
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        if (err_count < PRINT_CAP)
            $display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        err_count++;
    endtask

    // ---------------------------------------------------------------------
    // driver: bursts of transactions with random gaps
    // ---------------------------------------------------------------------
    ptt_item_t drv_item;
    int        burst_left = 0;
    int        gap_left   = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                expected_results.push_back(advance_timers(drv_item));
            // next beat only once the current one is gone
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (pending_items.size() != 0) begin
                    drv_item = pending_items.pop_front();
                    s_tdata  <= {3'b000, drv_item.one_shot, drv_item.period, drv_item.task_id};
                    s_tuser  <= drv_item.kind;
                    s_tvalid <= 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 12);
                        gap_left   = (tx_gap_max > 0) ? $urandom_range(0, tx_gap_max) : 0;
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // monitor: receiver stalls plus result check
    // ---------------------------------------------------------------------
    int hold_seen = 0;
    int hold_left = 0;
    int rx_phase  = 0;

    always @(posedge aclk) begin
        ptt_result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result", int'(m_tdata), 0);
                end else begin
                    want = expected_results.pop_front();
                    if (m_tdata[0] !== want.status)
                        report_mismatch("status", int'(m_tdata[0]), int'(want.status));
                    if (m_tdata[8:1] !== want.fired_mask)
                        report_mismatch("fired_mask", int'(m_tdata[8:1]),
                                        int'(want.fired_mask));
                    if (m_tdata[9] !== want.timer_enabled)
                        report_mismatch("timer_enabled", int'(m_tdata[9]),
                                        int'(want.timer_enabled));
                end
            end
            // long hold-off: the block fills and must stall its input
            if (hold_seen != hold_asks) begin
                hold_seen = hold_asks;
                hold_left = LONG_HOLD;
            end
            rx_phase = (rx_phase + 1) % 7;
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                case (rx_mode)
                    RX_ALWAYS:  m_tready <= 1'b1;
                    RX_COIN:    m_tready <= 1'($urandom_range(0, 1));
                    RX_PATTERN: m_tready <= (rx_phase < 3);
                    default:    m_tready <= ($urandom_range(0, 4) == 0);
                endcase
            end
        end
    end

    // ---------------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------------
    function automatic ptt_item_t make_item(logic [1:0] kind, logic [3:0] id,
                                            logic [15:0] per, logic once);
        ptt_item_t it;
        it.kind     = kind;
        it.task_id  = id;
        it.period   = per;
        it.one_shot = once;
        return it;
    endfunction

    // Mostly well-formed traffic: ticks dominate, starts use short periods so
    // slots actually fire; a fraction is bad ids, zero periods and junk kinds.
    function automatic ptt_item_t random_item();
        int sel;
        logic [15:0] per;
        logic [3:0]  id;
        sel = $urandom_range(0, 99);
        id  = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
                                          : 4'($urandom_range(0, TASK_SLOTS - 1));
        if (sel < 55)
            return make_item(KIND_TICK, 4'($urandom), 16'($urandom), 1'($urandom));
        if (sel < 78) begin
            case ($urandom_range(0, 9))
                0:       per = 16'($urandom);   // long period, any bit pattern
                1:       per = 16'd0;
                default: per = 16'($urandom_range(1, 10));
            endcase
            return make_item(KIND_START, id, per, 1'($urandom));
        end
        if (sel < 94)
            return make_item(KIND_STOP, id, 16'($urandom), 1'($urandom));
        return make_item(KIND_BAD, 4'($urandom), 16'($urandom), 1'($urandom));
    endfunction

    task automatic queue_item(logic [1:0] kind, logic [3:0] id, logic [15:0] per, logic once);
        pending_items.push_back(make_item(kind, id, per, once));
    endtask

    task automatic queue_random(int count);
        for (int i = 0; i < count; i++)
            pending_items.push_back(random_item());
    endtask

    task automatic queue_ticks(int count);
        for (int i = 0; i < count; i++)
            queue_item(KIND_TICK, 4'($urandom), 16'($urandom), 1'($urandom));
    endtask

    // Blocks until every transaction is sent and every result is back.
    task automatic wait_idle();
        while (pending_items.size() != 0 || expected_results.size() != 0 || s_tvalid)
            @(posedge aclk);
        repeat (IDLE_SETTLE) @(posedge aclk);
    endtask

    // APB write: setup, then access until pready; predictor follows the edge.
    task automatic write_reg(logic [2:0] addr, logic [31:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_TICKS_PER_BASE)
            cfg_tpb = value[7:0];
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // phase 1: directed, no idling, one base tick per raw tick
        write_reg(ADDR_TICKS_PER_BASE, 32'd1);
        tx_gap_max = 0;
        rx_mode    = RX_ALWAYS;
        queue_item(KIND_TICK,  4'd0,  16'hFFFF, 1'b1);  // ticking off: ignored
        queue_item(KIND_STOP,  4'd3,  16'd0,    1'b0);  // inactive stop
        queue_item(KIND_START, 4'd8,  16'd5,    1'b0);  // bad slot
        queue_item(KIND_START, 4'd15, 16'hFFFF, 1'b1);  // bad slot, top id
        queue_item(KIND_START, 4'd2,  16'd0,    1'b0);  // zero period
        queue_item(KIND_BAD,   4'd15, 16'hFFFF, 1'b1);  // unknown kind
        queue_item(KIND_START, 4'd0,  16'd1,    1'b0);  // fires every base tick
        queue_item(KIND_START, 4'd7,  16'hFFFF, 1'b1);  // longest period
        queue_item(KIND_START, 4'd1,  16'd2,    1'b1);  // one-shot
        queue_ticks(4);
        queue_item(KIND_START, 4'd0,  16'd3,    1'b0);  // restart active slot
        queue_ticks(3);
        queue_item(KIND_STOP,  4'd7,  16'd0,    1'b0);
        queue_item(KIND_STOP,  4'd15, 16'd0,    1'b0);  // bad slot
        queue_item(KIND_STOP,  4'd7,  16'd0,    1'b0);  // already stopped
        queue_ticks(1);
        queue_item(KIND_STOP,  4'd0,  16'd0,    1'b0);  // last one: ticking off
        queue_ticks(1);
        wait_idle();

        // phase 2: random traffic with gaps; long hold-off early on, then a
        // full pause in the middle of the phase
        write_reg(ADDR_TICKS_PER_BASE, 32'd2);
        tx_gap_max = 6;
        rx_mode    = RX_COIN;
        queue_random(70);
        hold_asks++;
        wait_idle();
        queue_random(70);
        wait_idle();

        // phase 3: prescaler at 255; a couple of slots and enough raw ticks
        // for one base tick, leaving the prescaler part way through
        write_reg(ADDR_TICKS_PER_BASE, 32'd255);
        rx_mode = RX_PATTERN;
        queue_item(KIND_START, 4'd4, 16'd1, 1'b0);
        queue_item(KIND_START, 4'd5, 16'd2, 1'b1);
        queue_ticks(300);
        queue_item(KIND_STOP, 4'd4, 16'd0, 1'b0);
        queue_ticks(2);
        wait_idle();

        // phase 4: back to the fastest setting with a partly filled prescaler,
        // so it has to wrap before the next base tick; sparse receiver
        write_reg(ADDR_TICKS_PER_BASE, 32'd1);
        tx_gap_max = 20;
        rx_mode    = RX_SPARSE;
        queue_random(250);
        wait_idle();

        // phase 5: random prescale, no idling on either side
        write_reg(ADDR_TICKS_PER_BASE, 32'($urandom_range(1, 4)));
        tx_gap_max = 0;
        rx_mode    = RX_ALWAYS;
        queue_random(50);
        wait_idle();

        if (err_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // watchdog, far above the slowest legal run
    initial begin
        #20ms;
        $display("Regression FAIL");
        $finish;
    end

endmodule
